// ===== hw/rtl/fbw_pkg.sv =====
package fbw_pkg;

    // field masks and offsets of a single-precision word
    localparam logic [31:0] EXP_FIELD = 32'h7F80_0000;
    localparam logic [31:0] EXP_ADD   = 32'h3F80_0000 >> 1;
    localparam logic [31:0] BIT30_CLR = ~32'h4000_0000;
    localparam logic [31:0] SGN_EXP   = 32'hFF80_0000;

    localparam int MNT_W    = 23;
    localparam int P_W      = 15;                  // mantissa top bits used by light modes
    localparam int PP_W     = 2 * P_W;
    localparam int SQ_SHIFT = MNT_W - P_W - 1;     // light1 square scaling
    localparam int Q_SHIFT  = P_W;                 // light2 square scaling
    localparam int DD_SHIFT = 12;                  // light2 second square scaling
    localparam int DS_W     = PP_W - DD_SHIFT;
    localparam int A_W      = 8;
    localparam int K_W      = DS_W + A_W;

    localparam logic [A_W-1:0] LIGHT2_A = 8'd215;

    typedef enum logic [2:0] {
        MODE_SQRT    = 3'd0,
        MODE_BELT    = 3'd1,
        MODE_BADMOOD = 3'd2,
        MODE_LIGHT1  = 3'd3,
        MODE_LIGHT2  = 3'd4,
        MODE_LIGHT3  = 3'd5
    } shape_mode_t;

    typedef struct packed {
        logic [31:0] sample_in;
        logic        block_end_in;
    } fbw_in_t;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        block_end_out;
    } fbw_out_t;

    // load enables of the three mantissa stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } fbw_stage_en_t;

endpackage

// ===== hw/rtl/fbw_bit_shaper.sv =====
module fbw_bit_shaper (
    input  logic [31:0]             x,
    input  logic [2:0]              mode,
    input  logic [fbw_pkg::MNT_W-1:0] light1_mnt,
    output logic [31:0]             base
);
    import fbw_pkg::*;

    logic [31:0] asr;
    logic [31:0] expo;
    logic [31:0] belt;
    logic        live;

    assign asr  = {x[31], x[31:1]};
    assign expo = x & EXP_FIELD;
    assign belt = x - expo + {1'b0, expo[31:1]} + EXP_ADD;
    // exponent field above code one
    assign live = x[30:23] > 8'd1;

    always_comb
    begin
        unique case (mode)
            MODE_SQRT:    base = live ? ((asr & BIT30_CLR) + EXP_ADD) : 32'd0;
            MODE_BELT:    base = live ? belt : 32'd0;
            MODE_BADMOOD: base = live ? (belt ^ {x[23], 31'd0}) : 32'd0;
            MODE_LIGHT1:  base = (x & SGN_EXP) | {{(32-MNT_W){1'b0}}, light1_mnt};
            MODE_LIGHT2:  base = x & SGN_EXP;
            MODE_LIGHT3:  base = x & SGN_EXP;
            default:      base = x;
        endcase
    end

endmodule

// ===== hw/rtl/fbw_mant_pipe.sv =====
module fbw_mant_pipe (
    input  logic                        clk,
    input  fbw_pkg::fbw_stage_en_t      en,
    input  logic [fbw_pkg::MNT_W-1:0]   mnt,
    output logic [fbw_pkg::MNT_W-1:0]   light1_mnt,
    output logic [fbw_pkg::MNT_W-1:0]   light2_mnt
);
    import fbw_pkg::*;

    logic [PP_W-1:0]  pp_reg,  pp_next;
    logic [MNT_W-1:0] m1_reg;
    logic [PP_W-1:0]  dd_reg,  dd_next;
    logic [MNT_W-1:0] m2_reg;
    logic [K_W-1:0]   k_reg,   k_next;
    logic [MNT_W-1:0] m3_reg;
    logic [P_W-1:0]   p_in;
    logic [P_W-1:0]   p1;
    logic [P_W-1:0]   q1;
    logic [P_W-1:0]   d1;

    // stage 1: square of the mantissa top bits
    assign p_in    = mnt[MNT_W-1 -: P_W];
    assign pp_next = p_in * p_in;

    // stage 2: distance from the square, squared again
    assign p1      = m1_reg[MNT_W-1 -: P_W];
    assign q1      = pp_reg[PP_W-1 -: P_W];
    assign d1      = p1 - q1;
    assign dd_next = d1 * d1;

    // stage 3: scale by the shaping constant
    assign k_next  = dd_reg[PP_W-1 -: DS_W] * LIGHT2_A;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pp_reg <= pp_next;
            m1_reg <= mnt;
        end
        if (en.s2)
        begin
            dd_reg <= dd_next;
            m2_reg <= m1_reg;
        end
        if (en.s3)
        begin
            k_reg  <= k_next;
            m3_reg <= m2_reg;
        end
    end

    assign light1_mnt = pp_reg[SQ_SHIFT +: MNT_W];
    // clamp at zero when the correction exceeds the mantissa
    assign light2_mnt = (k_reg > {{(K_W-MNT_W){1'b0}}, m3_reg}) ? '0
                      : (m3_reg - k_reg[MNT_W-1:0]);

endmodule

// ===== hw/rtl/float_bit_waveshaper_core.sv =====
// channel  | direction | handshake                  | payload
// sample   | in        | sample_valid / sample_stall | fbw_in_t  (sample_in, block_end_in)
// shaped   | out       | shaped_valid / shaped_stall | fbw_out_t (sample_out, block_end_out)
// config   | in        | config_valid / config_ready | shape_mode, 3 bits
//
// one sample per clock while shaped_stall is low; a sample passes through
// three register stages for the mantissa squares and the light2 scaling, then the output register
// each stage holds only while it is full and the stage after it cannot take its item,
// so bubbles close up under an output stall and nothing is lost or repeated
// rst_n clears the valid bits and the mode register; the datapath is not reset
// config_ready is always high; shape_mode is sampled with each sample as it enters
module float_bit_waveshaper_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  fbw_pkg::fbw_in_t sample,
    output logic             shaped_valid,
    input  logic             shaped_stall,
    output fbw_pkg::fbw_out_t shaped,
    input  logic             config_valid,
    output logic             config_ready,
    input  logic [2:0]       config_data
);
    import fbw_pkg::*;

    // mode register
    logic [2:0] mode_reg;

    // control path: valid bits of each stage
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic adv1, adv2, adv3, advo;

    // data carried alongside the mantissa pipe
    logic [31:0] x1_reg;
    logic [2:0]  mode1_reg, mode2_reg, mode3_reg;
    logic        be1_reg, be2_reg, be3_reg;
    logic [31:0] base2_reg, base3_reg;
    logic [31:0] base_next;
    fbw_out_t    out_reg, out_next;

    fbw_stage_en_t        en;
    logic [MNT_W-1:0]     light1_mnt;
    logic [MNT_W-1:0]     light2_mnt;

    assign config_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SQRT;
        end
        else if (config_valid && config_ready)
        begin
            mode_reg <= config_data;
        end
    end

    // a stage moves on when it is empty or when the next stage moves on
    assign advo   = !vo_reg || !shaped_stall;
    assign adv3   = !v3_reg || advo;
    assign adv2   = !v2_reg || adv3;
    assign adv1   = !v1_reg || adv2;
    assign sample_stall = !adv1;

    assign en.s1 = adv1;
    assign en.s2 = adv2;
    assign en.s3 = adv3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= sample_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (advo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    // squares and the light2 correction
    fbw_mant_pipe u_mant_pipe (
        .clk        (clk),
        .en         (en),
        .mnt        (sample.sample_in[MNT_W-1:0]),
        .light1_mnt (light1_mnt),
        .light2_mnt (light2_mnt)
    );

    // field-level shapes, resolved in stage 2
    fbw_bit_shaper u_bit_shaper (
        .x          (x1_reg),
        .mode       (mode1_reg),
        .light1_mnt (light1_mnt),
        .base       (base_next)
    );

    // light2 fills in its mantissa at the last stage; all else passes straight
    always_comb
    begin
        out_next.block_end_out = be3_reg;
        if (mode3_reg == MODE_LIGHT2)
        begin
            out_next.sample_out = base3_reg | {{(32-MNT_W){1'b0}}, light2_mnt};
        end
        else
        begin
            out_next.sample_out = base3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg    <= sample.sample_in;
            be1_reg   <= sample.block_end_in;
            mode1_reg <= mode_reg;
        end
        if (adv2)
        begin
            base2_reg <= base_next;
            be2_reg   <= be1_reg;
            mode2_reg <= mode1_reg;
        end
        if (adv3)
        begin
            base3_reg <= base2_reg;
            be3_reg   <= be2_reg;
            mode3_reg <= mode2_reg;
        end
        if (advo)
        begin
            out_reg <= out_next;
        end
    end

    assign shaped_valid = vo_reg;
    assign shaped       = out_reg;

endmodule

// ===== hw/rtl/fbw_checker.sv =====
module fbw_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input fbw_pkg::fbw_in_t sample,
    input logic             shaped_valid,
    input logic             shaped_stall,
    input fbw_pkg::fbw_out_t shaped
);
    import fbw_pkg::*;

    logic in_xfer;
    assign in_xfer = sample_valid && !sample_stall;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        shaped_valid && shaped_stall |=> shaped_valid)
        else $error("shaped_valid dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        shaped_valid && shaped_stall |=> $stable(shaped))
        else $error("shaped payload changed under stall");

    // with the output empty the pipe always takes a sample
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !shaped_valid |-> !sample_stall)
        else $error("sample stalled with empty output");

    // a transferred sample is offered at the output when the output does not stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer ##1 !shaped_stall ##1 !shaped_stall ##1 !shaped_stall |=> shaped_valid)
        else $error("sample did not arrive after four cycles");

    // block marker travels with its sample
    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer ##1 !shaped_stall ##1 !shaped_stall ##1 !shaped_stall
        |=> shaped.block_end_out == $past(sample.block_end_in, 4))
        else $error("block_end_out does not match its sample");

endmodule

bind float_bit_waveshaper_core fbw_checker u_fbw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .shaped_valid (shaped_valid),
    .shaped_stall (shaped_stall),
    .shaped       (shaped)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fbw_pkg::*;

    // fields of a single-precision word that the package does not name
    localparam logic [31:0] EXP_LSB   = 32'h0080_0000;
    localparam logic [31:0] MNT_FIELD = 32'h007F_FFFF;

    // mode codes outside the enum: the block passes the sample through
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // drain wait after the queues empty, covering the pipe plus margin
    localparam int PIPE_LATENCY = 8;
    localparam int RANDOM_PER_PHASE = 42;
    localparam int PHASES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        sample_valid = 1'b0;
    logic        sample_stall;
    fbw_in_t     sample = '0;
    logic        shaped_valid;
    logic        shaped_stall = 1'b0;
    fbw_out_t    shaped;
    logic        config_valid = 1'b0;
    logic        config_ready;
    logic [2:0]  config_data = '0;

    // testbench copy of the mode register, reset value is sqrt
    logic [2:0]  active_mode = MODE_SQRT;

    fbw_in_t     sample_backlog[$];
    fbw_out_t    shaped_due[$];
    fbw_out_t    want;
    logic        sample_taken = 1'b0;

    // idle and stall chances in percent, set per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned mode_writes = 0;

    float_bit_waveshaper_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .shaped_valid (shaped_valid),
        .shaped_stall (shaped_stall),
        .shaped       (shaped),
        .config_valid (config_valid),
        .config_ready (config_ready),
        .config_data  (config_data)
    );

    always #1 clk = ~clk;

    // expected bit pattern for one sample under the given mode
    function automatic logic [31:0] shape_sample(input logic [31:0] x, input logic [2:0] mode);
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] r;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] d;
        logic [31:0] k;
        logic        live;
        e = x & EXP_FIELD;
        m = x & MNT_FIELD;
        live = e > EXP_LSB;
        p = m >> (MNT_W - P_W);
        case (mode)
            MODE_SQRT:
            begin
                // arithmetic halving of the whole word
                r = ({x[31], x[31:1]} & BIT30_CLR) + EXP_ADD;
                r = live ? r : '0;
            end
            MODE_BELT:
            begin
                r = x - e + (e >> 1) + EXP_ADD;
                r = live ? r : '0;
            end
            MODE_BADMOOD:
            begin
                // sign flips when the exponent lsb is set
                r = (x - e + (e >> 1) + EXP_ADD) ^ ((x & EXP_LSB) << 8);
                r = live ? r : '0;
            end
            MODE_LIGHT1:
            begin
                r = (x & SGN_EXP) | (((p * p) >> SQ_SHIFT) & MNT_FIELD);
            end
            MODE_LIGHT2:
            begin
                q = (p * p) >> Q_SHIFT;
                d = p - q;
                k = ((d * d) >> DD_SHIFT) * LIGHT2_A;
                // mantissa clamps at zero on underflow
                r = (x & SGN_EXP) | (((k > m) ? 32'd0 : (m - k)) & MNT_FIELD);
            end
            MODE_LIGHT3:
            begin
                r = x & SGN_EXP;
            end
            default:
            begin
                r = x;
            end
        endcase
        return r;
    endfunction

    // sample driver: a new transfer is offered only once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || sample_taken))
        begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample <= sample_backlog.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        shaped_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // predict each sample at the edge where its transfer happens
    always @(posedge clk)
    begin
        sample_taken <= sample_valid && !sample_stall;
        if (rst_n && sample_valid && !sample_stall)
        begin
            shaped_due.push_back(fbw_out_t'{
                sample_out:    shape_sample(sample.sample_in, active_mode),
                block_end_out: sample.block_end_in});
        end
    end

    // compare every shaped transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && shaped_valid && !shaped_stall)
        begin
            if (shaped_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected shaped transfer, expected none, actual %h/%b",
                         $time, shaped.sample_out, shaped.block_end_out);
            end
            else
            begin
                want = shaped_due.pop_front();
                checked++;
                if (shaped.sample_out !== want.sample_out)
                begin
                    mismatches++;
                    $display("%0t: sample_out mismatch, expected %h, actual %h",
                             $time, want.sample_out, shaped.sample_out);
                end
                if (shaped.block_end_out !== want.block_end_out)
                begin
                    mismatches++;
                    $display("%0t: block_end_out mismatch, expected %b, actual %b",
                             $time, want.block_end_out, shaped.block_end_out);
                end
            end
        end
    end

    // mode register write, only while nothing is in flight
    task automatic load_mode(input logic [2:0] mode);
        @(negedge clk);
        config_valid <= 1'b1;
        config_data <= mode;
        do @(posedge clk); while (!config_ready);
        active_mode = mode;
        mode_writes++;
        @(negedge clk);
        config_valid <= 1'b0;
    endtask

    // wait until every queued sample has gone through and been checked
    task automatic wait_drained();
        while (sample_backlog.size() != 0 || sample_valid || shaped_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // idle patterns: none, sender gaps, receiver stalls, both lightly
    task automatic set_idling(input int pattern);
        case (pattern % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    initial
    begin
        logic [2:0]  dir_modes[8];
        logic [31:0] dir_special[8];
        logic [2:0]  phase_modes[PHASES];
        logic [31:0] v;

        dir_modes = '{MODE_SQRT, MODE_BELT, MODE_BADMOOD, MODE_LIGHT1,
                      MODE_LIGHT2, MODE_LIGHT3, MODE_SPARE6, MODE_SPARE7};
        // one case of interest per mode
        dir_special = '{32'h8100_0000,   // negative, exponent just above the zero threshold
                        32'h0080_0000,   // exponent exactly at the zero threshold
                        32'h3F80_0000,   // exponent lsb set, sign flips
                        32'h007F_FFFF,   // denormal with full mantissa
                        32'h002A_AB00,   // mantissa near the deepest light2 cut
                        32'h7FC0_0001,   // nan
                        32'h1234_5678,
                        32'hDEAD_BEEF};
        phase_modes = '{MODE_SQRT, MODE_BELT, MODE_BADMOOD, MODE_LIGHT1,
                        MODE_LIGHT2, MODE_LIGHT3, MODE_SPARE6, MODE_SPARE7,
                        MODE_LIGHT2, MODE_LIGHT1, MODE_BADMOOD, MODE_SQRT};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero, all ones and one special pattern in every mode
        for (int i = 0; i < 8; i++)
        begin
            set_idling(i);
            load_mode(dir_modes[i]);
            sample_backlog.push_back(fbw_in_t'{sample_in: 32'h0000_0000, block_end_in: 1'b0});
            sample_backlog.push_back(fbw_in_t'{sample_in: 32'hFFFF_FFFF, block_end_in: 1'b1});
            sample_backlog.push_back(fbw_in_t'{sample_in: dir_special[i], block_end_in: 1'b0});
            wait_drained();
        end

        // random: a quarter of the samples get an exponent at the edges of its range
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_idling(ph);
            load_mode(phase_modes[ph]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                v = $urandom;
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 4))
                        0: v[30:23] = 8'h00;
                        1: v[30:23] = 8'h01;
                        2: v[30:23] = 8'h02;
                        3: v[30:23] = 8'hFE;
                        default: v[30:23] = 8'hFF;
                    endcase
                end
                sample_backlog.push_back(fbw_in_t'{sample_in: v,
                                                   block_end_in: 1'($urandom_range(0, 1))});
            end
            wait_drained();
        end

        $display("checked %0d shaped transfers over %0d mode writes,", checked, mode_writes);
        $display("all six shapes and both spare codes under steady flow, sender gaps, receiver stalls and light mixed idling");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("Verification failed");
        $finish;
    end

endmodule
